[sv/stereo_cascaded_biquad_equalizer_core_macros.svh]
// Assertion macros used by the checker file of the equalizer core.
// Depends on nothing; included by bare file name.
`ifndef STEREO_CASCADED_BIQUAD_EQUALIZER_CORE_MACROS_SVH
`define STEREO_CASCADED_BIQUAD_EQUALIZER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SCBE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the next one.
`define SCBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same, but also checked while reset is applied.
`define SCBE_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/scbe_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers of the equalizer core.
// Depends on nothing; used by scbe_mac, the top level and the testbench.
package scbe_pkg;

  localparam int BANDS            = 10;
  localparam int COEF_FRAC_BITS   = 28;
  localparam int SIGNAL_FRAC_BITS = 24;
  localparam int SLOTS            = 5;
  localparam int HIST             = 4;
  localparam int CW               = 32;
  localparam int ACC_W            = 68;
  localparam int PROD_W           = 64;
  localparam int GAIN_W           = 15;
  localparam int SAMPLE_W         = 16;
  localparam int BAND_W           = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int COEF_ROW_W       = SLOTS * CW;
  localparam int HIST_ROW_W       = 2 * HIST * CW;
  localparam int CH_W             = HIST * CW;

  localparam logic [GAIN_W-1:0] OUT_GAIN_RESET = 15'd19661;

  // Coefficient slots.
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // Item kinds on the input tuser bit.
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // Row of a band that was never written: b0 = 1.0, all others zero.
  localparam logic [COEF_ROW_W-1:0] COEF_RESET_ROW =
    COEF_ROW_W'(CW'(1) << COEF_FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD,
    ST_CWR,
    ST_RD,
    ST_MUL,
    ST_DRAIN,
    ST_WB,
    ST_GL,
    ST_GR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
    logic neg;
    logic ch;
  } mac_ctl_t;

  // Round half up at the coefficient point and saturate to 32 bits.
  function automatic logic signed [CW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(CW-1){1'b1}}});
    lo = ~hi;
    t  = acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    t  = t >>> COEF_FRAC_BITS;
    if (t > hi) begin
      t = hi;
    end else if (t < lo) begin
      t = lo;
    end
    return t[CW-1:0];
  endfunction

  // Clamp the gained value to +-1.0 and convert to 16-bit PCM, truncating toward zero.
  function automatic logic [SAMPLE_W-1:0] out_conv(input logic signed [PROD_W-1:0] v);
    logic                  neg;
    logic [PROD_W-1:0]     mag;
    logic [PROD_W-1:0]     lim;
    logic [PROD_W+15:0]    scaled;
    logic [SAMPLE_W-1:0]   res;
    lim = PROD_W'(1) << (SIGNAL_FRAC_BITS + 15);
    neg = v[PROD_W-1];
    mag = neg ? PROD_W'(-v) : PROD_W'(v);
    if (mag > lim) begin
      mag = lim;
    end
    scaled = ({16'd0, mag} << 15) - {16'd0, mag};
    scaled = scaled >> (SIGNAL_FRAC_BITS + 15);
    res    = scaled[SAMPLE_W-1:0];
    return neg ? SAMPLE_W'(-res) : res;
  endfunction

endpackage

[sv/scbe_mac.sv]
`timescale 1ns / 1ps
// Shared multiplier with a product register and two channel accumulators.
// Depends on scbe_pkg.
module scbe_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  scbe_pkg::mac_ctl_t                   ctl,
  input  logic signed [scbe_pkg::CW-1:0]       a,
  input  logic signed [scbe_pkg::CW-1:0]       b,
  output logic signed [scbe_pkg::PROD_W-1:0]   prod,
  output logic signed [scbe_pkg::CW-1:0]       y_l,
  output logic signed [scbe_pkg::CW-1:0]       y_r
);

  logic signed [scbe_pkg::PROD_W-1:0] prod_r;
  scbe_pkg::mac_ctl_t                 ctl_r;
  logic signed [scbe_pkg::ACC_W-1:0]  acc_l_r;
  logic signed [scbe_pkg::ACC_W-1:0]  acc_r_r;
  logic signed [scbe_pkg::ACC_W-1:0]  term;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  assign term = ctl_r.neg ? -scbe_pkg::ACC_W'(prod_r) : scbe_pkg::ACC_W'(prod_r);

  // The product of the control issued in the previous cycle is added here.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctl_r.acc_en) begin
      if (ctl_r.ch) begin
        acc_r_r <= acc_r_r + term;
      end else begin
        acc_l_r <= acc_l_r + term;
      end
    end
  end

  assign prod = prod_r;
  assign y_l  = scbe_pkg::round_sat(acc_l_r);
  assign y_r  = scbe_pkg::round_sat(acc_r_r);

endmodule

[sv/stereo_cascaded_biquad_equalizer_core.sv]
`timescale 1ns / 1ps
// Top level of the stereo cascaded biquad equalizer: sequencer, coefficient
// and history memories, output stage. Depends on scbe_pkg and scbe_mac.
//
//  Channel | Dir | Beat contents
//  --------+-----+----------------------------------------------------------
//  in_     | in  | tuser: func; tdata: left_in, right_in, band_index,
//          |     |   coef_index, coef_value (low bits first)
//  out_    | out | tdata: left_out, right_out (low bits first)
//  cfg_    | in  | cfg_we strobes cfg_wdata into out_gain
//
// A stereo frame walks the bands in turn, each with one memory read, ten
// multiplies on the shared multiplier, one drain and one write back, then
// runs the gain stage and the output load. The next beat is taken in the idle
// state after that, so a new frame is not taken before the last one is done.
// A coefficient beat passes read, modify and write states; an ignored
// coefficient beat is dropped in the idle state. Reset is synchronous and
// active low; it clears the control state and the per-band valid bits, so
// every band reads as identity coefficients with empty history right away,
// with no clearing pass. A stalled result holds in the output register while
// the next input beat is taken and processed; the core only waits if a second
// result is done before the first one leaves.
module stereo_cascaded_biquad_equalizer_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields: left_in[15:0], right_in[31:16], band_index[35:32],
  // coef_index[38:36], coef_value[70:39], zero pad [71].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  // in_tuser fields: func[0].
  input  logic        in_tuser,
  // out_tdata fields: left_out[15:0], right_out[31:16].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam int CW = scbe_pkg::CW;

  // Input fields.
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;
  logic [3:0]         in_band;
  logic [2:0]         in_slot;
  logic [31:0]        in_cval;
  logic [4:0]         in_band_ext;
  logic               in_acc;
  logic               coef_ok;

  assign in_left     = in_tdata[15:0];
  assign in_right    = in_tdata[31:16];
  assign in_band     = in_tdata[35:32];
  assign in_slot     = in_tdata[38:36];
  assign in_cval     = in_tdata[70:39];
  assign in_band_ext = {1'b0, in_band};
  assign in_acc      = in_tvalid && in_tready;
  assign coef_ok     = (32'(in_band) < 32'(scbe_pkg::BANDS)) && (in_slot <= scbe_pkg::SLOT_A2);

  // Control and payload registers.
  scbe_pkg::state_t                state_r, state_nxt;
  logic [scbe_pkg::BAND_W-1:0]     band_r, band_nxt;
  logic [3:0]                      k_r, k_nxt;
  logic [2:0]                      slot_r;
  logic [CW-1:0]                   cval_r;
  logic signed [CW-1:0]            x_l_r, x_r_r;
  logic [scbe_pkg::BANDS-1:0]      coef_vld_r, hist_vld_r;
  logic [scbe_pkg::GAIN_W-1:0]     gain_r;
  logic [15:0]                     res_l_r;
  logic                            out_vld_r;
  logic [31:0]                     out_data_r;

  // Memories, one row per band.
  logic [scbe_pkg::COEF_ROW_W-1:0] coef_mem [scbe_pkg::BANDS];
  logic [scbe_pkg::HIST_ROW_W-1:0] hist_mem [scbe_pkg::BANDS];
  logic [scbe_pkg::COEF_ROW_W-1:0] coef_q_r;
  logic [scbe_pkg::HIST_ROW_W-1:0] hist_q_r;
  logic [scbe_pkg::BAND_W-1:0]     rd_addr;
  logic [scbe_pkg::COEF_ROW_W-1:0] coef_eff, coef_wdata;
  logic [scbe_pkg::HIST_ROW_W-1:0] hist_eff, hist_wdata;
  logic                            coef_we, hist_we;

  // MAC interface.
  scbe_pkg::mac_ctl_t              mac_ctl;
  logic signed [CW-1:0]            mac_a, mac_b;
  logic signed [scbe_pkg::PROD_W-1:0] mac_prod;
  logic signed [CW-1:0]            y_l, y_r;

  logic [2:0]                      mslot;
  logic                            mch;
  logic                            out_load;
  logic                            last_band;

  // A coefficient beat addresses the memory straight from the bus so the
  // row is ready in the next cycle; a frame walks band_r.
  assign rd_addr = (state_r == scbe_pkg::ST_IDLE) ? in_band_ext[scbe_pkg::BAND_W-1:0] : band_r;

  always_ff @(posedge clk) begin
    coef_q_r <= coef_mem[rd_addr];
    hist_q_r <= hist_mem[rd_addr];
    if (coef_we) begin
      coef_mem[band_r] <= coef_wdata;
    end
    if (hist_we) begin
      hist_mem[band_r] <= hist_wdata;
    end
  end

  // Rows of bands never written since reset, or cleared by a coefficient
  // write, read as their reset value.
  assign coef_eff = coef_vld_r[band_r] ? coef_q_r : scbe_pkg::COEF_RESET_ROW;
  assign hist_eff = hist_vld_r[band_r] ? hist_q_r : '0;

  always_comb begin
    coef_wdata = coef_eff;
    coef_wdata[32'(slot_r) * CW +: CW] = cval_r;
  end

  // New history: x1 = band input, x2 = old x1, y1 = band output, y2 = old y1.
  assign hist_wdata = {hist_eff[CW*6 +: CW], y_r, hist_eff[CW*4 +: CW], x_r_r,
                       hist_eff[CW*2 +: CW], y_l, hist_eff[0 +: CW], x_l_r};

  assign last_band = (band_r == scbe_pkg::BAND_W'(scbe_pkg::BANDS - 1));
  assign mch       = (k_r >= 4'd5);
  assign mslot     = mch ? 3'(k_r - 4'd5) : k_r[2:0];
  assign out_load  = (state_r == scbe_pkg::ST_FIN) && (!out_vld_r || out_tready);

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_a = coef_eff[32'(mslot) * CW +: CW];
    case (mslot)
      scbe_pkg::SLOT_B0: mac_b = mch ? x_r_r : x_l_r;
      scbe_pkg::SLOT_B1: mac_b = hist_eff[32'(mch) * scbe_pkg::CH_W + 0 * CW +: CW];
      scbe_pkg::SLOT_B2: mac_b = hist_eff[32'(mch) * scbe_pkg::CH_W + 1 * CW +: CW];
      scbe_pkg::SLOT_A1: mac_b = hist_eff[32'(mch) * scbe_pkg::CH_W + 2 * CW +: CW];
      scbe_pkg::SLOT_A2: mac_b = hist_eff[32'(mch) * scbe_pkg::CH_W + 3 * CW +: CW];
      default:           mac_b = '0;
    endcase
    if (state_r == scbe_pkg::ST_GL) begin
      mac_a = x_l_r;
      mac_b = CW'(gain_r);
    end else if ((state_r == scbe_pkg::ST_GR) || (state_r == scbe_pkg::ST_FIN)) begin
      mac_a = x_r_r;
      mac_b = CW'(gain_r);
    end
  end

  // Next state and control.
  always_comb begin
    state_nxt      = state_r;
    band_nxt       = band_r;
    k_nxt          = k_r;
    coef_we        = 1'b0;
    hist_we        = 1'b0;
    mac_ctl        = '0;
    in_tready      = (state_r == scbe_pkg::ST_IDLE);
    case (state_r)
      scbe_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == scbe_pkg::FUNC_COEF) begin
            band_nxt  = in_band_ext[scbe_pkg::BAND_W-1:0];
            state_nxt = coef_ok ? scbe_pkg::ST_CRD : scbe_pkg::ST_IDLE;
          end else begin
            band_nxt  = '0;
            state_nxt = scbe_pkg::ST_RD;
          end
        end
      end
      scbe_pkg::ST_CRD: state_nxt = scbe_pkg::ST_CWR;
      scbe_pkg::ST_CWR: begin
        coef_we   = 1'b1;
        state_nxt = scbe_pkg::ST_IDLE;
      end
      scbe_pkg::ST_RD: begin
        mac_ctl.clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = scbe_pkg::ST_MUL;
      end
      scbe_pkg::ST_MUL: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.neg    = (mslot == scbe_pkg::SLOT_A1) || (mslot == scbe_pkg::SLOT_A2);
        mac_ctl.ch     = mch;
        k_nxt          = k_r + 4'd1;
        if (k_r == 4'd9) begin
          state_nxt = scbe_pkg::ST_DRAIN;
        end
      end
      scbe_pkg::ST_DRAIN: state_nxt = scbe_pkg::ST_WB;
      scbe_pkg::ST_WB: begin
        hist_we = 1'b1;
        if (last_band) begin
          state_nxt = scbe_pkg::ST_GL;
        end else begin
          band_nxt  = band_r + scbe_pkg::BAND_W'(1);
          state_nxt = scbe_pkg::ST_RD;
        end
      end
      scbe_pkg::ST_GL: state_nxt = scbe_pkg::ST_GR;
      scbe_pkg::ST_GR: state_nxt = scbe_pkg::ST_FIN;
      scbe_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = scbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= scbe_pkg::ST_IDLE;
      band_r     <= '0;
      k_r        <= '0;
      coef_vld_r <= '0;
      hist_vld_r <= '0;
      gain_r     <= scbe_pkg::OUT_GAIN_RESET;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      // A coefficient write clears both channels' history of that band.
      if (coef_we) begin
        coef_vld_r[band_r] <= 1'b1;
        hist_vld_r[band_r] <= 1'b0;
      end
      if (hist_we) begin
        hist_vld_r[band_r] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= in_slot;
      cval_r <= in_cval;
      // Sample to Q8.24: scale by 2^(SIGNAL_FRAC_BITS-15).
      x_l_r  <= CW'(in_left)  <<< (scbe_pkg::SIGNAL_FRAC_BITS - 15);
      x_r_r  <= CW'(in_right) <<< (scbe_pkg::SIGNAL_FRAC_BITS - 15);
    end else if (state_r == scbe_pkg::ST_WB) begin
      x_l_r <= y_l;
      x_r_r <= y_r;
    end
    if (state_r == scbe_pkg::ST_GR) begin
      res_l_r <= scbe_pkg::out_conv(mac_prod);
    end
    if (out_load) begin
      out_data_r <= {scbe_pkg::out_conv(mac_prod), res_l_r};
    end
  end

  scbe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .prod  (mac_prod),
    .y_l   (y_l),
    .y_r   (y_r)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/scbe_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the equalizer core, bound to the top level.
// Depends on the assertion macro header.
`include "stereo_cascaded_biquad_equalizer_core_macros.svh"

module scbe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `SCBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `SCBE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `SCBE_ASSERT_ALWAYS(a_out_range, clk, rst_n, !out_tvalid || ((out_tdata[15:0] != 16'h8000) && (out_tdata[31:16] != 16'h8000)), "output sample outside clamp range")
  `SCBE_ASSERT_NEXT_RST(a_reset_empty, clk, !rst_n, !out_tvalid, "result present after reset")

endmodule

bind stereo_cascaded_biquad_equalizer_core scbe_chk u_scbe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/tb_stereo_cascaded_biquad_equalizer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the stereo cascaded biquad equalizer core.
// Depends on scbe_pkg and the core RTL; needs no files or arguments.
module tb_stereo_cascaded_biquad_equalizer_core;

  // One input beat as the testbench sees it, fields at the block's widths.
  typedef struct packed {
    logic               func;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic [3:0]         band_index;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
  } eq_beat_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } eq_frame_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [14:0] cfg_wdata;

  stereo_cascaded_biquad_equalizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: its own copy of coefficients, per-channel history and gain.
  logic signed [31:0] eq_coefs [scbe_pkg::BANDS*scbe_pkg::SLOTS];
  logic signed [31:0] left_hist [scbe_pkg::BANDS*scbe_pkg::HIST];
  logic signed [31:0] right_hist [scbe_pkg::BANDS*scbe_pkg::HIST];
  logic [14:0]        gain_reg;

  eq_beat_t  pending_beats[$];
  eq_frame_t expected_frames[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_sender;
  bit  run_done;
  int  mismatches;
  int  frames_checked;
  int  quiet_cycles;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor division by 2^COEF_FRAC_BITS; an arithmetic shift is exactly floor.
  function automatic logic signed [95:0] floor_coef(input logic signed [95:0] p);
    return p >>> scbe_pkg::COEF_FRAC_BITS;
  endfunction

  // Predictor state after reset: identity coefficients, empty history.
  function automatic void reset_model();
    int b;
    int s;
    for (b = 0; b < scbe_pkg::BANDS; b++)
      for (s = 0; s < scbe_pkg::SLOTS; s++)
        eq_coefs[b*scbe_pkg::SLOTS+s] = (s == scbe_pkg::SLOT_B0) ?
          (32'sd1 <<< scbe_pkg::COEF_FRAC_BITS) : 32'sd0;
    for (b = 0; b < scbe_pkg::BANDS*scbe_pkg::HIST; b++) begin
      left_hist[b]  = '0;
      right_hist[b] = '0;
    end
  endfunction

  // One direct-form-I biquad; the history row is updated in place.
  function automatic logic signed [31:0] biquad_band(input int band,
                                                     input logic signed [31:0] x,
                                                     input bit right_ch);
    logic signed [95:0] acc;
    logic signed [95:0] y;
    logic signed [31:0] h [scbe_pkg::HIST];
    logic signed [31:0] ysat;
    int k;
    int cb;
    cb = band * scbe_pkg::SLOTS;
    for (k = 0; k < scbe_pkg::HIST; k++)
      h[k] = right_ch ? right_hist[band*scbe_pkg::HIST+k] : left_hist[band*scbe_pkg::HIST+k];
    // Summing exact products then rounding once equals the core's one-product-at-a-time accumulation.
    acc = 96'(eq_coefs[cb+scbe_pkg::SLOT_B0]) * 96'(x)
        + 96'(eq_coefs[cb+scbe_pkg::SLOT_B1]) * 96'(h[0])
        + 96'(eq_coefs[cb+scbe_pkg::SLOT_B2]) * 96'(h[1])
        - 96'(eq_coefs[cb+scbe_pkg::SLOT_A1]) * 96'(h[2])
        - 96'(eq_coefs[cb+scbe_pkg::SLOT_A2]) * 96'(h[3]);
    y = floor_coef(acc + (96'sd1 <<< (scbe_pkg::COEF_FRAC_BITS - 1)));
    if (y > 96'sd2147483647) ysat = 32'sh7fffffff;
    else if (y < -96'sd2147483648) ysat = 32'sh80000000;
    else ysat = y[31:0];
    h[1] = h[0];
    h[0] = x;
    h[3] = h[2];
    h[2] = ysat;
    for (k = 0; k < scbe_pkg::HIST; k++) begin
      if (right_ch) right_hist[band*scbe_pkg::HIST+k] = h[k];
      else left_hist[band*scbe_pkg::HIST+k] = h[k];
    end
    return ysat;
  endfunction

  function automatic logic signed [15:0] equalize_channel(input logic signed [15:0] s,
                                                          input bit right_ch);
    logic signed [31:0] x;
    logic signed [63:0] v;
    logic signed [63:0] lim;
    logic [63:0]        mag;
    logic [63:0]        r;
    int b;
    x = 32'(s) <<< (scbe_pkg::SIGNAL_FRAC_BITS - 15);
    for (b = 0; b < scbe_pkg::BANDS; b++) x = biquad_band(b, x, right_ch);
    v = 64'(x) * $signed({49'd0, gain_reg});
    lim = 64'sd1 <<< (scbe_pkg::SIGNAL_FRAC_BITS + 15);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    mag = (v < 0) ? -v : v;
    r = (mag * 64'd32767) >> (scbe_pkg::SIGNAL_FRAC_BITS + 15);
    return (v < 0) ? -16'(r) : 16'(r);
  endfunction

  // Applies one accepted beat to the predictor and queues its result, if any.
  function automatic void predict_beat(input eq_beat_t bt);
    eq_frame_t f;
    int k;
    if (bt.func == scbe_pkg::FUNC_COEF) begin
      if (bt.band_index < scbe_pkg::BANDS && bt.coef_index < scbe_pkg::SLOTS) begin
        eq_coefs[bt.band_index*scbe_pkg::SLOTS+bt.coef_index] = bt.coef_value;
        for (k = 0; k < scbe_pkg::HIST; k++) begin
          left_hist[bt.band_index*scbe_pkg::HIST+k]  = '0;
          right_hist[bt.band_index*scbe_pkg::HIST+k] = '0;
        end
      end
    end else begin
      f.left_out  = equalize_channel(bt.left_in, 1'b0);
      f.right_out = equalize_channel(bt.right_in, 1'b1);
      expected_frames.push_back(f);
    end
  endfunction

  function automatic eq_beat_t rand_frame();
    eq_beat_t bt;
    bt.func       = scbe_pkg::FUNC_FILTER;
    bt.left_in    = 16'($urandom);
    bt.right_in   = 16'($urandom);
    bt.band_index = 4'($urandom);
    bt.coef_index = 3'($urandom);
    bt.coef_value = 32'($urandom);
    // Mix in some small left samples so quiet signals are common too.
    if ($urandom_range(3) == 0) bt.left_in = $signed(16'($urandom_range(64))) - 16'sd32;
    return bt;
  endfunction

  // Coefficients kept mostly stable-ish: small terms within +-0.5 unless wild, then random.
  function automatic eq_beat_t rand_coef(input bit wild);
    eq_beat_t bt;
    bt = rand_frame();
    bt.func       = scbe_pkg::FUNC_COEF;
    bt.band_index = wild ? 4'($urandom) : 4'($urandom_range(scbe_pkg::BANDS - 1));
    bt.coef_index = wild ? 3'($urandom) : 3'($urandom_range(scbe_pkg::SLOTS - 1));
    if (wild) bt.coef_value = 32'($urandom);
    else bt.coef_value = $signed(32'($urandom_range(32'h1000_0000))) - 32'sh0800_0000;
    return bt;
  endfunction

  function automatic eq_beat_t make_frame(input logic signed [15:0] l,
                                          input logic signed [15:0] r);
    eq_beat_t bt;
    bt = rand_frame();
    bt.left_in  = l;
    bt.right_in = r;
    return bt;
  endfunction

  function automatic eq_beat_t make_coef(input int band, input int slot,
                                         input logic signed [31:0] val);
    eq_beat_t bt;
    bt = rand_frame();
    bt.func       = scbe_pkg::FUNC_COEF;
    bt.band_index = 4'(band);
    bt.coef_index = 3'(slot);
    bt.coef_value = val;
    return bt;
  endfunction

  // Driver: presents queued beats; valid stays high across back-to-back beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= scbe_pkg::FUNC_FILTER;
      reset_model();
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_beat({in_tuser, in_tdata[15:0], in_tdata[31:16],
                                   in_tdata[35:32], in_tdata[38:36], in_tdata[70:39]});
      if (pending_beats.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        eq_beat_t bt;
        bt = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= bt.func;
        in_tdata  <= {1'b0, bt.coef_value, bt.coef_index, bt.band_index,
                      bt.right_in, bt.left_in};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat against the oldest expected frame.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat %h", out_tdata);
        end else begin
          eq_frame_t f;
          f = expected_frames.pop_front();
          if (out_tdata[15:0] !== f.left_out || out_tdata[31:16] !== f.right_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: frame %0d expected L=%0d R=%0d, got L=%0d R=%0d",
                       frames_checked, f.left_out, f.right_out,
                       $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
          end
        end
        frames_checked++;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if (!run_done) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_tvalid || expected_frames.size() > 0)
      @(posedge clk);
    // A trailing coefficient beat gives no result; let it finish.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gain(input logic [14:0] g);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    gain_reg   = g;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    int n;
    int r;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 70) pending_beats.push_back(rand_frame());
      else if (r < 92) pending_beats.push_back(rand_coef(1'b0));
      else pending_beats.push_back(rand_coef(1'b1));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_sender = 1'b0;
    run_done = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 86;
    gain_reg = scbe_pkg::OUT_GAIN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset gain, sample extremes, every slot, ignored writes.
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    pending_beats.push_back(make_frame(16'sh0000, 16'shffff));
    pending_beats.push_back(make_frame(16'sh0001, 16'sh5555));
    pending_beats.push_back(make_coef(0, scbe_pkg::SLOT_B0, 32'sh7fffffff));
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    pending_beats.push_back(make_coef(0, scbe_pkg::SLOT_B0, 32'sh80000000));
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    pending_beats.push_back(make_coef(0, scbe_pkg::SLOT_B0, 32'sh1000_0000));
    pending_beats.push_back(make_coef(3, scbe_pkg::SLOT_B1, 32'sh0800_0000));
    pending_beats.push_back(make_coef(3, scbe_pkg::SLOT_B2, -32'sh0400_0000));
    pending_beats.push_back(make_coef(9, scbe_pkg::SLOT_A1, -32'sh1000_0000));
    pending_beats.push_back(make_coef(9, scbe_pkg::SLOT_A2, 32'sh0600_0000));
    pending_beats.push_back(make_frame(16'sh4000, -16'sh4000));
    pending_beats.push_back(make_frame(16'sh2000, 16'sh1000));
    pending_beats.push_back(make_coef(10, scbe_pkg::SLOT_B0, 32'sh0));  // band out of range
    pending_beats.push_back(make_coef(15, scbe_pkg::SLOT_A2, 32'sh0));
    pending_beats.push_back(make_coef(2, 5, 32'sh0));         // slot out of range
    pending_beats.push_back(make_coef(2, 7, 32'sh0));
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    pending_beats.push_back(make_frame(-16'sh0001, 16'sh0001));
    wait_idle();

    write_gain(15'd32767);
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    pending_beats.push_back(make_frame(16'sh1234, -16'sh1234));
    wait_idle();
    write_gain(15'd0);
    pending_beats.push_back(make_frame(16'sh7fff, 16'sh8000));
    wait_idle();
    write_gain(15'($urandom));

    // Random part in three idle settings, with a full drain between each.
    queue_random(150);
    // Once half the beats are sent, pause the sender until every queued result is back.
    while (pending_beats.size() > 75) @(posedge clk);
    hold_sender = 1'b1;
    while (in_tvalid || expected_frames.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_idle();

    send_idle_pct = 86;
    recv_idle_pct = 32;
    write_gain(15'($urandom));
    queue_random(150);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(scbe_pkg::OUT_GAIN_RESET);
    queue_random(150);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done = 1'b1;
    $display("Covered %0d result frames across gain settings 0, full scale and random,",
             frames_checked);
    $display("with coefficient loads, ignored writes and varied idling on both sides.");
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d frames still expected", mismatches,
               expected_frames.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
